// ----- hdl/ced_pkg.sv -----
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants for the capability escape decoder
// Holds the request and result payload types, the work entry passed from the
// front end to the back end, the decoder mode codes and the byte mappings.
// ----------------------------------------------------------------------------
package ced_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] ESCAPE_RESET = 8'd92;
   localparam logic [7:0] CHAR_CARET   = 8'h5e;
   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CTRL_MASK    = 8'o037;
   localparam logic [7:0] CTRL_ESC     = 8'o033;

   // Decoder modes.
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_ESC   = 2'd1;
   localparam logic [1:0] MODE_CARET = 2'd2;
   localparam logic [1:0] MODE_OCTAL = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        carries_byte;
      logic        end_of_run;
      logic [15:0] decoded_length;
   } rsp_type;

   // One classified request: up to two decoded bytes and the end marker.
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [1:0] byte_count;
      logic       is_final;
   } work_type;

   function automatic logic [7:0] map_escape(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         8'h45:   r = CTRL_ESC;  // E
         8'h72:   r = 8'o015;    // r
         8'h6e:   r = 8'o012;    // n
         8'h62:   r = 8'o010;    // b
         8'h74:   r = 8'o011;    // t
         8'h66:   r = 8'o014;    // f
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] map_caret(input logic [7:0] b);
      logic is_ctrl;
      is_ctrl = (b == CHAR_AT) ||
                (b >= 8'h61 && b <= 8'h7a) ||
                (b >= 8'h41 && b <= 8'h5a);
      return is_ctrl ? (b & CTRL_MASK) : b;
   endfunction

endpackage

// ----- hdl/ced_front.sv -----
// ----------------------------------------------------------------------------
// ced_front: request classifier
// Tracks the escape, caret and octal modes and turns each request into a
// work entry holding the bytes it decodes to. Owns the escape byte register.
// ----------------------------------------------------------------------------
module ced_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              accept,
   input  ced_pkg::req_type  req_data,
   output ced_pkg::work_type work
);

   logic [7:0] escape_ff, escape_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] oval_ff, oval_in;
   logic [1:0] odig_ff, odig_in;
   logic [1:0] olim_ff, olim_in;

   logic [7:0] b;
   logic       is_digit;
   logic [2:0] digit;
   logic [1:0] dig_sum;
   logic [7:0] val_sum;
   logic [7:0] e0, e1;
   logic [1:0] n;

   assign b        = req_data.in_byte;
   assign is_digit = (b[7:3] == 5'b00110);
   assign digit    = b[2:0];
   assign dig_sum  = odig_ff + 2'd1;
   assign val_sum  = {oval_ff[4:0], digit};
   assign escape_in = csr_wr_en ? csr_wr_data : escape_ff;

   always_comb begin
      mode_in = mode_ff;
      oval_in = oval_ff;
      odig_in = odig_ff;
      olim_in = olim_ff;
      e0      = 8'd0;
      e1      = 8'd0;
      n       = 2'd0;
      unique case (mode_ff)
         ced_pkg::MODE_ESC: begin
            if (is_digit) begin
               oval_in = {5'd0, digit};
               odig_in = 2'd1;
               olim_in = digit[2] ? 2'd2 : 2'd3;
               mode_in = ced_pkg::MODE_OCTAL;
            end else begin
               e0      = ced_pkg::map_escape(b);
               n       = 2'd1;
               mode_in = ced_pkg::MODE_PLAIN;
            end
         end
         ced_pkg::MODE_CARET: begin
            e0      = ced_pkg::map_caret(b);
            n       = 2'd1;
            mode_in = ced_pkg::MODE_PLAIN;
         end
         ced_pkg::MODE_OCTAL: begin
            if (is_digit) begin
               oval_in = val_sum;
               odig_in = dig_sum;
               if (dig_sum >= olim_ff) begin
                  e0      = val_sum;
                  n       = 2'd1;
                  mode_in = ced_pkg::MODE_PLAIN;
               end
            end else begin
               // The pending run goes out first, then the byte is plain.
               e0 = oval_ff;
               n  = 2'd1;
               priority if (b == escape_ff) begin
                  mode_in = ced_pkg::MODE_ESC;
               end else if (b == ced_pkg::CHAR_CARET) begin
                  mode_in = ced_pkg::MODE_CARET;
               end else begin
                  e1      = b;
                  n       = 2'd2;
                  mode_in = ced_pkg::MODE_PLAIN;
               end
            end
         end
         ced_pkg::MODE_PLAIN: begin
            priority if (b == escape_ff) begin
               mode_in = ced_pkg::MODE_ESC;
            end else if (b == ced_pkg::CHAR_CARET) begin
               mode_in = ced_pkg::MODE_CARET;
            end else begin
               e0 = b;
               n  = 2'd1;
            end
         end
      endcase

      if (req_data.is_final) begin
         if (mode_in == ced_pkg::MODE_OCTAL) begin
            e0 = oval_in;
            n  = 2'd1;
         end else if (mode_in == ced_pkg::MODE_CARET) begin
            if (n == 2'd0) begin
               e0 = ced_pkg::CHAR_CARET;
            end else begin
               e1 = ced_pkg::CHAR_CARET;
            end
            n = n + 2'd1;
         end
         mode_in = ced_pkg::MODE_PLAIN;
         oval_in = 8'd0;
         odig_in = 2'd0;
         olim_in = 2'd3;
      end
   end

   assign work.first_byte  = e0;
   assign work.second_byte = e1;
   assign work.byte_count  = n;
   assign work.is_final    = req_data.is_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= ced_pkg::ESCAPE_RESET;
         mode_ff   <= ced_pkg::MODE_PLAIN;
         oval_ff   <= 8'd0;
         odig_ff   <= 2'd0;
         olim_ff   <= 2'd3;
      end else begin
         escape_ff <= escape_in;
         if (accept) begin
            mode_ff <= mode_in;
            oval_ff <= oval_in;
            odig_ff <= odig_in;
            olim_ff <= olim_in;
         end
      end
   end

   // While a run is open it has fewer digits than its limit.
   a_octal_open: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ced_pkg::MODE_OCTAL |-> odig_ff < olim_ff)
      else $error("octal run open at its digit limit");

endmodule

// ----- hdl/ced_queue.sv -----
// ----------------------------------------------------------------------------
// ced_queue: work queue between the classifier and the emitter
// A small register queue with a fall-through head.
// ----------------------------------------------------------------------------
module ced_queue #(
   parameter int DEPTH = ced_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  ced_pkg::work_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output ced_pkg::work_type rd_data,
   output logic              empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   ced_pkg::work_type        slot_ff [DEPTH];
   logic [PTR_BITS-1:0]      wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]      rptr_ff, rptr_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rptr_ff];

   assign wptr_in = do_wr ? ((wptr_ff == LAST_PTR) ? '0 : wptr_ff + 1'b1) : wptr_ff;
   assign rptr_in = do_rd ? ((rptr_ff == LAST_PTR) ? '0 : rptr_ff + 1'b1) : rptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("work queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wptr_ff == rptr_ff))
      else $error("empty work queue with pointers apart");

endmodule

// ----- hdl/ced_back.sv -----
// ----------------------------------------------------------------------------
// ced_back: result emitter
// Walks the bytes of each work entry, keeps the saturating length count and
// holds the result register that the response side pops.
// ----------------------------------------------------------------------------
module ced_back #(
   parameter int LENGTH_BITS = ced_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ced_pkg::work_type work,
   input  logic              work_empty,
   output logic              work_pop,
   input  logic              rsp_pop,
   output logic              rsp_valid,
   output ced_pkg::rsp_type  rsp_data
);

   localparam int WIDE_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   logic                   sub_ff, sub_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   valid_ff, valid_in;
   ced_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   slot_free;
   logic                   step;
   logic                   has_byte;
   logic                   last;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [LENGTH_BITS-1:0] len_shown;
   logic [WIDE_BITS-1:0]   len_wide;

   assign slot_free = !valid_ff || rsp_pop;
   assign step      = slot_free && !work_empty;
   assign has_byte  = (work.byte_count != 2'd0);
   assign last      = !has_byte || (work.byte_count == 2'd1) || sub_ff;
   assign len_inc   = (len_ff == '1) ? len_ff : len_ff + 1'b1;
   assign len_shown = has_byte ? len_inc : len_ff;
   assign len_wide  = WIDE_BITS'(len_shown);
   assign work_pop  = step && last;

   always_comb begin
      sub_in   = sub_ff;
      len_in   = len_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (rsp_pop) begin
         valid_in = 1'b0;
      end
      if (step) begin
         valid_in              = 1'b1;
         rsp_in.out_byte       = has_byte ? (sub_ff ? work.second_byte : work.first_byte)
                                          : 8'd0;
         rsp_in.carries_byte   = has_byte;
         rsp_in.end_of_run     = work.is_final && last;
         rsp_in.decoded_length = len_wide[15:0];
         sub_in                = !last;
         len_in                = (work.is_final && last) ? '0 : len_shown;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 1'b0;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   // A request that decodes to nothing only produces its end marker.
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ff.carries_byte |-> rsp_ff.end_of_run)
      else $error("byte-less result without end marker");

   // The second byte is only ever pending on a two-byte entry.
   a_second_byte: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> !work_empty && work.byte_count == 2'd2)
      else $error("second byte pending without a two-byte entry");

endmodule

// ----- hdl/capability_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// capability_escape_decoder: capability string escape decoder
// Decodes an escaped capability string one request byte at a time into the
// bytes it stands for, with a running saturating length per string.
// ----------------------------------------------------------------------------
// Path: an accepted request reaches the result ports through the queue slot
// and then the result register. Throughput: one request per cycle while full
// is low; the emitter writes one result per cycle while its result register
// is free, so a two-byte request holds it for both bytes. Reset (synchronous,
// active high) empties the work queue and result register, returns the decoder
// to plain mode, clears the length count and sets the escape byte to backslash.
// ----------------------------------------------------------------------------
//
// The front end (ced_front) classifies each request against the current mode
// (plain, escape, caret, octal run) and the escape byte register, and turns
// it into a work entry of zero, one or two decoded bytes plus the end flag.
// A request that only opens an escape or caret produces an empty entry unless
// it is the last byte of the string; the last byte always produces at least
// one result so the end of the string is seen on the response side.
//
// The work queue (ced_queue) decouples the two sides: the front end keeps
// taking requests while the emitter is busy with a two-byte entry or while
// the response side is stalled, until the queue fills. full follows the work queue directly.
// Entries without bytes that are not the end of a string are dropped at the
// queue head, one per cycle, so they never reach the emitter.
//
// The back end (ced_back) expands each entry into results, counts the bytes
// emitted in the current string with a counter that saturates at its top, and
// clears that count after the end-of-string result.
//
module capability_escape_decoder #(
   parameter int LENGTH_BITS = ced_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ced_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // Request side
   input  logic             push,
   output logic             full,
   input  ced_pkg::req_type req_data,
   // Result side
   output logic             empty,
   input  logic             pop,
   output ced_pkg::rsp_type rsp_data,
   // Escape byte register
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   ced_pkg::work_type front_work;
   ced_pkg::work_type head_work;
   ced_pkg::work_type back_work;
   logic              accept;
   logic              queue_full;
   logic              queue_empty;
   logic              queue_pop;
   logic              keep_entry;
   logic              back_empty;
   logic              back_pop;
   logic              rsp_valid;

   assign full   = queue_full;
   assign accept = push && !queue_full;

   ced_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_data    (req_data),
      .work        (front_work)
   );

   ced_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_work),
      .full    (queue_full),
      .rd_en   (queue_pop),
      .rd_data (head_work),
      .empty   (queue_empty)
   );

   // An entry with no bytes and no end marker carries nothing; it is
   // discarded at the queue head so the emitter never sees it.
   assign keep_entry = (head_work.byte_count != 2'd0) || head_work.is_final;
   assign back_empty = queue_empty || !keep_entry;
   assign back_work  = head_work;

   assign queue_pop = back_pop || (!queue_empty && !keep_entry);

   ced_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .work       (back_work),
      .work_empty (back_empty),
      .work_pop   (back_pop),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign empty = !rsp_valid;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the capability escape decoder
// Feeds encoded capability strings through the request queue, predicts every
// decoded result in the testbench, and checks each popped result in order.
// ----------------------------------------------------------------------------
module tb;

   // The block is built with its default length counter width.
   localparam int      LENGTH_BITS  = ced_pkg::LENGTH_BITS_DEFAULT;
   localparam longint  LENGTH_TOP   = (longint'(1) << LENGTH_BITS) - 1;
   localparam int      STALL_LIMIT  = 4000;
   localparam int      DRAIN_CYCLES = 8;
   localparam int      RANDOM_ITEMS = 360;
   localparam int      LONG_STRING  = 300;
   localparam int      REPORT_LIMIT = 10;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             push        = 1'b0;
   logic             full;
   ced_pkg::req_type req_data    = '0;
   logic             empty;
   logic             pop         = 1'b0;
   ced_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [7:0]       csr_wr_data = 8'd0;

   capability_escape_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Decoder state as the testbench sees it. It mirrors the block's escape
   // register and the per-string decoding state, and is advanced once for
   // every request that the block accepts.
   // -------------------------------------------------------------------------
   logic [7:0] escape_value = ced_pkg::ESCAPE_RESET;
   logic [1:0] decode_state = ced_pkg::MODE_PLAIN;
   logic [7:0] octal_acc    = 8'd0;
   logic [1:0] octal_count  = 2'd0;
   logic [1:0] octal_stop   = 2'd3;
   longint     bytes_out    = 0;

   // Results of the request being decoded, and all results still owed.
   ced_pkg::rsp_type step_rsp[2];
   int               step_count;
   ced_pkg::rsp_type decoded_queue[$];

   int               failures      = 0;
   int               items_sent    = 0;
   int               send_idle_pct = 0;
   int               stall_pct     = 0;
   int               quiet_cycles  = 0;
   ced_pkg::rsp_type due;

   function automatic void note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   // One decoded byte. The length counter sticks at its top value, and the
   // result port carries its low 16 bits. A request never yields more than
   // two bytes.
   function automatic void emit_decoded(input logic [7:0] b);
      if (step_count < 2) begin
         if (bytes_out < LENGTH_TOP)
            bytes_out++;
         step_rsp[step_count] = '{out_byte: b, carries_byte: 1'b1, end_of_run: 1'b0,
                                  decoded_length: bytes_out[15:0]};
         step_count++;
      end
   endfunction

   function automatic logic is_octal_digit(input logic [7:0] b);
      return (b >= "0") && (b <= "7");
   endfunction

   // A byte seen in plain mode either opens an escape, opens a caret pair,
   // or stands for itself. The escape test comes first so that an escape
   // byte equal to the caret behaves as an escape.
   function automatic void take_plain(input logic [7:0] b);
      if (b == escape_value)
         decode_state = ced_pkg::MODE_ESC;
      else if (b == ced_pkg::CHAR_CARET)
         decode_state = ced_pkg::MODE_CARET;
      else
         emit_decoded(b);
   endfunction

   function automatic logic [7:0] escaped_letter(input logic [7:0] b);
      case (b)
         "E":     return 8'o033;
         "r":     return 8'o015;
         "n":     return 8'o012;
         "b":     return 8'o010;
         "t":     return 8'o011;
         "f":     return 8'o014;
         default: return b;
      endcase
   endfunction

   // Works out the results of one accepted request and queues them.
   function automatic void decode_request(input ced_pkg::req_type item);
      logic [7:0] b;
      b = item.in_byte;
      step_count = 0;
      case (decode_state)
         ced_pkg::MODE_ESC: begin
            decode_state = ced_pkg::MODE_PLAIN;
            if (is_octal_digit(b)) begin
               // A run that starts at 4 to 7 can only hold two digits.
               octal_acc    = b - "0";
               octal_count  = 2'd1;
               octal_stop   = (b <= "3") ? 2'd3 : 2'd2;
               decode_state = ced_pkg::MODE_OCTAL;
            end else begin
               emit_decoded(escaped_letter(b));
            end
         end
         ced_pkg::MODE_CARET: begin
            decode_state = ced_pkg::MODE_PLAIN;
            if (b == "@" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
               emit_decoded(b & 8'o037);
            else
               emit_decoded(b);
         end
         ced_pkg::MODE_OCTAL: begin
            if (is_octal_digit(b)) begin
               octal_acc   = {octal_acc[4:0], 3'b000} + (b - "0");
               octal_count = octal_count + 2'd1;
               if (octal_count >= octal_stop) begin
                  emit_decoded(octal_acc);
                  decode_state = ced_pkg::MODE_PLAIN;
               end
            end else begin
               // A non-digit closes the run, then counts as a plain byte.
               emit_decoded(octal_acc);
               decode_state = ced_pkg::MODE_PLAIN;
               take_plain(b);
            end
         end
         default: begin
            decode_state = ced_pkg::MODE_PLAIN;
            take_plain(b);
         end
      endcase

      if (item.is_final) begin
         // A pending run is flushed, a pending caret stands for itself and
         // a pending escape is dropped. The string always ends on a result,
         // an empty one if nothing else was decoded.
         if (decode_state == ced_pkg::MODE_OCTAL)
            emit_decoded(octal_acc);
         else if (decode_state == ced_pkg::MODE_CARET)
            emit_decoded(ced_pkg::CHAR_CARET);
         if (step_count == 0) begin
            step_rsp[0] = '{out_byte: 8'd0, carries_byte: 1'b0, end_of_run: 1'b0,
                            decoded_length: bytes_out[15:0]};
            step_count  = 1;
         end
         step_rsp[step_count - 1].end_of_run = 1'b1;
         decode_state = ced_pkg::MODE_PLAIN;
         octal_acc    = 8'd0;
         octal_count  = 2'd0;
         octal_stop   = 2'd3;
         bytes_out    = 0;
      end

      for (int i = 0; i < step_count; i++)
         decoded_queue.push_back(step_rsp[i]);
   endfunction

   // -------------------------------------------------------------------------
   // Request side. push stays high from one request to the next; it is
   // lowered only for an idle gap or when the caller stops sending, so the
   // same time step never sees two assignments to it.
   // -------------------------------------------------------------------------
   task automatic push_request(input logic [7:0] b, input logic fin);
      ced_pkg::req_type item;
      item.in_byte  = b;
      item.is_final = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (full)
         @(posedge clock);
      decode_request(item);
      items_sent++;
   endtask

   // Sends a string literal as one capability string, final on its last byte.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_request(s[i], i == s.len() - 1);
   endtask

   // Stops sending and waits until every owed result has been popped. Requests
   // that decode to nothing may still sit in the pipeline, so the bench lets
   // them drain before anything else touches the block.
   task automatic wait_idle();
      push <= 1'b0;
      while (decoded_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_escape(input logic [7:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      escape_value  = value;
   endtask

   // -------------------------------------------------------------------------
   // Result side. pop is redrawn every cycle from the current stall rate, and
   // each popped result is compared with the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock)
      pop <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (decoded_queue.size() == 0) begin
            note_failure($sformatf("unexpected result byte=%h carries=%b end=%b len=%0d",
                                   rsp_data.out_byte, rsp_data.carries_byte,
                                   rsp_data.end_of_run, rsp_data.decoded_length));
         end else begin
            due = decoded_queue.pop_front();
            if (rsp_data.out_byte !== due.out_byte ||
                rsp_data.carries_byte !== due.carries_byte ||
                rsp_data.end_of_run !== due.end_of_run ||
                rsp_data.decoded_length !== due.decoded_length)
               note_failure($sformatf({"expected byte=%h carries=%b end=%b len=%0d, ",
                                       "got byte=%h carries=%b end=%b len=%0d"},
                                      due.out_byte, due.carries_byte, due.end_of_run,
                                      due.decoded_length, rsp_data.out_byte,
                                      rsp_data.carries_byte, rsp_data.end_of_run,
                                      rsp_data.decoded_length));
         end
      end
   end

   // Watchdog: a long stretch in which neither side moves anything means the
   // block has hung.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Every control letter after the escape byte, plus one letter that has no
   // mapping and so passes through.
   task automatic test_escape_letters();
      send_text("\\E\\r\\n\\b\\t\\f\\q");
   endtask

   // A full three-digit run at the top of the byte range, a run that starts
   // at 4 and stops after two digits so the third digit is plain, a run cut
   // short by a non-digit, and a run still open at the end of the string.
   task automatic test_octal_runs();
      send_text("\\377\\477\\5x\\1");
   endtask

   // Caret with '@', a lower and an upper case letter, a byte that is not a
   // letter, and a caret left open at the end of the string.
   task automatic test_caret_pairs();
      send_text("^@^a^Z^~^");
   endtask

   // A string that is only an escape byte decodes to nothing and ends on an
   // empty result; a zero byte decodes as itself.
   task automatic test_string_end();
      send_text("\\");
      push_request(8'h00, 1'b1);
   endtask

   // The escape register at the caret, where the escape meaning wins, and at
   // both ends of its range.
   task automatic test_escape_register();
      write_escape(ced_pkg::CHAR_CARET);
      send_text("^n^");
      write_escape(8'hff);
      push_request(8'hff, 1'b0);
      push_request("t", 1'b1);
      write_escape(8'h00);
      push_request(8'h00, 1'b0);
      push_request("E", 1'b1);
      write_escape(ced_pkg::ESCAPE_RESET);
   endtask

   // One long string, so the length count carries well past its low byte
   // within a single string.
   task automatic test_long_string();
      repeat (LONG_STRING - 1) push_request("a", 1'b0);
      push_request("a", 1'b1);
   endtask

   // Builds one random capability string. Most strings are made of proper
   // escape, caret and octal sequences with random content; some end with an
   // escape, caret or octal run left open, and some are plain noise.
   task automatic send_random_string();
      logic [7:0] text[$];
      int         tokens;
      int         extra;
      tokens = $urandom_range(1, 10);
      if ($urandom_range(99) < 10) begin
         repeat (tokens) text.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat (tokens) begin
            case ($urandom_range(9))
               0, 1, 2: begin
                  text.push_back(8'($urandom_range(1, 255)));
               end
               3, 4: begin
                  text.push_back(escape_value);
                  case ($urandom_range(6))
                     0: text.push_back("E");
                     1: text.push_back("r");
                     2: text.push_back("n");
                     3: text.push_back("b");
                     4: text.push_back("t");
                     5: text.push_back("f");
                     default: text.push_back(8'($urandom_range(1, 255)));
                  endcase
               end
               5, 6: begin
                  // Digits past the run's limit fall back to plain bytes.
                  text.push_back(escape_value);
                  extra = $urandom_range(0, 3);
                  repeat (extra + 1) text.push_back(8'("0" + $urandom_range(7)));
               end
               7, 8: begin
                  text.push_back(ced_pkg::CHAR_CARET);
                  case ($urandom_range(3))
                     0: text.push_back("@");
                     1: text.push_back(8'("a" + $urandom_range(25)));
                     2: text.push_back(8'("A" + $urandom_range(25)));
                     default: text.push_back(8'($urandom_range(1, 255)));
                  endcase
               end
               default: begin
                  text.push_back(escape_value);
                  text.push_back(8'($urandom_range(1, 255)));
               end
            endcase
         end
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(2))
               0: text.push_back(escape_value);
               1: text.push_back(ced_pkg::CHAR_CARET);
               default: begin
                  text.push_back(escape_value);
                  extra = $urandom_range(0, 1);
                  repeat (extra + 1) text.push_back(8'("0" + $urandom_range(7)));
               end
            endcase
         end
      end
      foreach (text[i])
         push_request(text[i], i == text.size() - 1);
   endtask

   // Random strings under one escape setting and one idling pattern.
   task automatic test_random_strings(input logic [7:0] escape_setting,
                                      input int send_idle, input int stall);
      int target;
      write_escape(escape_setting);
      send_idle_pct = send_idle;
      stall_pct     = stall;
      target        = items_sent + RANDOM_ITEMS;
      while (items_sent < target)
         send_random_string();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings run with both sides busy every cycle.
      test_escape_letters();
      test_octal_runs();
      test_caret_pairs();
      test_string_end();
      test_escape_register();
      test_long_string();

      // Random phases: no idling, a slow sender, a slow receiver, then both.
      test_random_strings(ced_pkg::ESCAPE_RESET, 0, 0);
      test_random_strings(8'hff, 76, 0);
      test_random_strings(8'h00, 0, 76);
      test_random_strings(ced_pkg::CHAR_CARET, 38, 38);

      wait_idle();
      if (failures == 0 && decoded_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
